[rtl/parallel_copy_sequencer_macros.svh]
// assertion macros shared by the sequencer modules
`ifndef PARALLEL_COPY_SEQUENCER_MACROS_SVH
`define PARALLEL_COPY_SEQUENCER_MACROS_SVH

// condition a implies condition c in the same cycle
`define PCS_ASSERT_IMP(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// condition a implies condition c in the next cycle
`define PCS_ASSERT_NXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

[rtl/pcs_pkg.sv]
// shared constants and types of the parallel copy sequencer
`default_nettype none
package pcs_pkg;

	localparam int DEF_MAX_COPIES = 32;
	localparam int DEF_REG_BITS   = 11;
	localparam int IN_REG_W       = 11;
	localparam int IDX_OUT_W      = 6;
	localparam int S_TDATA_W      = 24;
	localparam int M_TDATA_W      = 8;

	typedef enum logic [3:0] {
		S_LOAD = 4'b0001,
		S_SCAN = 4'b0010,
		S_CMP  = 4'b0100,
		S_DEC  = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic sched_set;
		logic clear;
		logic emit;
		logic stuck;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic sched_k;
		logic qualifies;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/pcs_ram.sv]
// generic single-write, registered-read ram
`default_nettype none
module pcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/pcs_datapath.sv]
// copy storage, lane comparators, scheduled flags and output register
`default_nettype none
`include "parallel_copy_sequencer_macros.svh"
module pcs_datapath import pcs_pkg::*; #(
	parameter int MAX_COPIES = DEF_MAX_COPIES,
	parameter int REG_BITS   = DEF_REG_BITS,
	parameter int IDX_W      = $clog2(MAX_COPIES),
	parameter int CNT_W      = $clog2(MAX_COPIES + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	input  wire logic [IDX_W-1:0]     k_idx,
	output sts_t                      sts,
	output logic      [CNT_W-1:0]     count,
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [M_TDATA_W-1:0] m_axis_tdata,
	output logic                      m_axis_tuser,
	output logic                      m_axis_tlast
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COPIES);

	logic [CNT_W-1:0]      count_q;
	logic [MAX_COPIES-1:0] sched_q;
	logic [REG_BITS-1:0]   src_lane_q [MAX_COPIES];
	logic [MAX_COPIES-1:0] match_q;
	logic                  self_q;
	logic                  wr_en;
	logic [REG_BITS-1:0]   in_dst;
	logic [REG_BITS-1:0]   in_src;
	logic [31:0]           dst_ext;
	logic [31:0]           src_ext;
	logic [2*REG_BITS-1:0] rdata;
	logic [REG_BITS-1:0]   rd_dst;
	logic [REG_BITS-1:0]   rd_src;
	logic                  out_valid_q;
	logic [IDX_OUT_W-1:0]  out_idx_q;
	logic                  out_stuck_q;
	logic                  out_last_q;
	logic                  out_free;

	assign dst_ext = 32'(signed'(s_axis_tdata[IN_REG_W-1:0]));
	assign src_ext = 32'(signed'(s_axis_tdata[2*IN_REG_W-1:IN_REG_W]));
	assign in_dst  = dst_ext[REG_BITS-1:0];
	assign in_src  = src_ext[REG_BITS-1:0];
	assign wr_en   = cmd.load && (count_q < MAX_CNT);

	pcs_ram #(
		.WIDTH(2 * REG_BITS),
		.DEPTH(MAX_COPIES)
	) u_copy_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({in_src, in_dst}),
		.raddr(k_idx),
		.rdata(rdata)
	);

	assign rd_dst = rdata[REG_BITS-1:0];
	assign rd_src = rdata[2*REG_BITS-1:REG_BITS];

	always_ff @(posedge clk) begin
		for (int m = 0; m < MAX_COPIES; m++) begin
			if (wr_en && (count_q == CNT_W'(m))) begin
				src_lane_q[m] <= in_src;
			end
		end
		if (cmd.cmp) begin
			self_q <= (rd_dst == rd_src);
			for (int m = 0; m < MAX_COPIES; m++) begin
				match_q[m] <= (CNT_W'(m) < count_q) && !sched_q[m]
					&& (IDX_W'(m) != k_idx) && (src_lane_q[m] == rd_dst);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sched_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sched_q <= '0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.sched_set) begin
				sched_q[k_idx] <= 1'b1;
			end
		end
	end

	// output beat register
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx_q   <= cmd.stuck ? '0 : IDX_OUT_W'(k_idx);
			out_stuck_q <= cmd.stuck;
			out_last_q  <= cmd.last;
		end
	end

	assign sts.sched_k   = sched_q[k_idx];
	assign sts.qualifies = self_q || !(|match_q);
	assign sts.out_free  = out_free;
	assign count         = count_q;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(out_idx_q);
	assign m_axis_tuser  = out_stuck_q;
	assign m_axis_tlast  = out_last_q;

	`PCS_ASSERT_IMP(a_no_overwrite, cmd.emit, out_free, "result beat overwritten")
	`PCS_ASSERT_IMP(a_sched_once, cmd.sched_set, !sched_q[k_idx], "copy scheduled twice")
	`PCS_ASSERT_NXT(a_group_cleared, cmd.clear, (count_q == '0) && (sched_q == '0), "group not cleared")

endmodule
`default_nettype wire

[rtl/pcs_ctrl.sv]
// ordering state machine with candidate and slot counters
`default_nettype none
`include "parallel_copy_sequencer_macros.svh"
module pcs_ctrl import pcs_pkg::*; #(
	parameter int MAX_COPIES = DEF_MAX_COPIES,
	parameter int IDX_W      = $clog2(MAX_COPIES),
	parameter int CNT_W      = $clog2(MAX_COPIES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic             s_axis_tlast,
	input  wire sts_t             sts,
	input  wire logic [CNT_W-1:0] count,
	output cmd_t                  cmd,
	output logic      [IDX_W-1:0] k_idx
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_d;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] pos_d;
	logic [CNT_W-1:0] pos_inc;
	logic             accept;

	assign s_axis_tready = (state_q == S_LOAD);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pos_inc       = pos_q + 1'b1;
	assign k_idx         = k_q[IDX_W-1:0];

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		pos_d   = pos_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				cmd.load = accept;
				if (accept && s_axis_tlast) begin
					k_d     = '0;
					pos_d   = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (k_q == count) begin
					// no pending copy qualifies: cycle
					if (sts.out_free) begin
						cmd.emit  = 1'b1;
						cmd.stuck = 1'b1;
						cmd.last  = 1'b1;
						cmd.clear = 1'b1;
						state_d   = S_LOAD;
					end
				end else if (sts.sched_k) begin
					k_d = k_q + 1'b1;
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.qualifies) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.sched_set = 1'b1;
						cmd.last      = (pos_inc == count);
						if (pos_inc == count) begin
							cmd.clear = 1'b1;
							state_d   = S_LOAD;
						end else begin
							pos_d   = pos_inc;
							k_d     = '0;
							state_d = S_SCAN;
						end
					end
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_SCAN;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			k_q     <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			pos_q   <= pos_d;
		end
	end

	`PCS_ASSERT_IMP(a_k_in_range, state_q != S_LOAD, k_q <= count, "candidate past group end")
	`PCS_ASSERT_IMP(a_pos_in_range, state_q != S_LOAD, pos_q < count, "slot past group end")
	`PCS_ASSERT_NXT(a_back_to_load, cmd.clear, state_q == S_LOAD, "group end not back to load")

endmodule
`default_nettype wire

[rtl/parallel_copy_sequencer.sv]
// Loading: one copy beat per cycle; a non-final beat produces no result.
// Ordering after the final beat: each candidate test runs ram read (S_SCAN), lane
// compare against the sources of other unscheduled copies (S_CMP) and decide (S_DEC);
// a scheduled copy is skipped in S_SCAN; S_DEC holds while the output register is busy.
// Input is not taken while a group is being ordered; the output register decouples m_axis.
// arst_n clears the state machine, copy count, scheduled flags and output valid.
`default_nettype none
module parallel_copy_sequencer import pcs_pkg::*; #(
	parameter int MAX_COPIES = DEF_MAX_COPIES,
	parameter int REG_BITS   = DEF_REG_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// dest_register [10:0], source_register [21:11], zero [23:22]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	input  wire logic                 s_axis_tlast,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// copy_index [5:0], zero [7:6]
	output logic      [M_TDATA_W-1:0] m_axis_tdata,
	// stuck [0]
	output logic                      m_axis_tuser,
	output logic                      m_axis_tlast
);

	localparam int IDX_W = $clog2(MAX_COPIES);
	localparam int CNT_W = $clog2(MAX_COPIES + 1);

	cmd_t             cmd;
	sts_t             sts;
	logic [IDX_W-1:0] k_idx;
	logic [CNT_W-1:0] count;

	pcs_ctrl #(
		.MAX_COPIES(MAX_COPIES),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tlast (s_axis_tlast),
		.sts          (sts),
		.count        (count),
		.cmd          (cmd),
		.k_idx        (k_idx)
	);

	pcs_datapath #(
		.MAX_COPIES(MAX_COPIES),
		.REG_BITS  (REG_BITS),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.k_idx        (k_idx),
		.sts          (sts),
		.count        (count),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
`default_nettype wire
